>>> design/pwi_pkg.sv
`default_nettype none

package pwi_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR = 3'd3;

  localparam int unsigned ERR_W   = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DRIVE_W = 32;
  // Magnitude of kd*(e-P) fits in 32 bits; divider runs one bit per cycle
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned DCNT_W  = 5;

  typedef struct packed {
    logic signed [ERR_W-1:0]  error_in;
    logic        [TICK_W-1:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      dt_zero;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_LOAD,
    ST_DIV,
    ST_SUM,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

>>> design/pid_windowed_integral_top.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_data_i   (pwi_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_data_o (pwi_pkg::out_t)
// cfg       input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// One item at a time: from accept the item passes the shared multiplier three
// times (P, I, D), then a load step, the one-bit-per-cycle restoring divider,
// a sum step and the final state; with zero elapsed_ticks the divider is skipped.
// The error ring lives in a RAM; the oldest entry is read at accept and the
// new one written back in the final cycle. Reset and a seed write need no
// clearing pass of the RAM. A result waiting on out_ready_i holds the final
// state; the next item is taken as soon as the result sits in the output register.

module pid_windowed_integral_top
  import pwi_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [GAIN_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW_DEPTH) + ERR_W + 1;
  localparam int unsigned OPA_W  = SUM_W + 1;
  localparam int unsigned PROD_W = OPA_W + GAIN_W;
  localparam int unsigned ACC_W  = PROD_W + 2;

  state_e state_q, state_d;

  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q, init_q;
  logic signed [ERR_W-1:0]  prev_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [FILL_W-1:0]        fill_q;
  logic [PTR_W-1:0]         wpos_q;
  logic                     seed_live_q;

  logic signed [ERR_W-1:0]  e_q;
  logic [TICK_W-1:0]        ticks_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DIV_W-1:0]         n_q;
  logic [TICK_W-1:0]        rem_q;
  logic [DCNT_W-1:0]        cnt_q;
  logic                     neg_q;

  logic out_valid_q;
  out_t out_q;

  logic in_fire, fin_go, seed_wr;
  logic ram_re, ram_we;
  logic [ERR_W-1:0] ram_rdata;

  assign in_fire = in_valid_i && in_ready_o;
  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign seed_wr = cfg_we_i && (cfg_idx_i == REG_INITIAL_ERROR);

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_LOAD;
      ST_LOAD:  state_d = (ticks_q == '0) ? ST_SUM : ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ram_re     = in_fire;
    ram_we     = fin_go;
  end

  // ---------------------------------------------------------- multiplier
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (state_q)
      ST_MUL_I: begin
        mul_a = OPA_W'(sum_q) + OPA_W'(e_q);
        mul_b = ki_q;
      end
      ST_MUL_D: begin
        mul_a = OPA_W'(e_q) - OPA_W'(prev_q);
        mul_b = kd_q;
      end
      default: begin
        mul_a = OPA_W'(e_q);
        mul_b = kp_q;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ------------------------------------------------------------- divider
  logic signed [DIV_W-1:0] dprod;
  logic [DIV_W-1:0]        dmag;
  logic [TICK_W:0]         rem_sh;
  logic                    qbit;
  logic signed [ACC_W-1:0] dterm;

  assign dprod  = prod_q[DIV_W-1:0];
  assign dmag   = dprod[DIV_W-1] ? DIV_W'(-dprod) : DIV_W'(dprod);
  assign rem_sh = {rem_q, n_q[DIV_W-1]};
  assign qbit   = (rem_sh >= {1'b0, ticks_q});
  assign dterm  = (ticks_q == '0) ? '0 :
                  (neg_q ? -$signed(ACC_W'(n_q)) : $signed(ACC_W'(n_q)));

  // ---------------------------------------------------------- round, sat
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign acc_sh = acc_q >>> 8;

  always_comb begin
    if ((&acc_sh[ACC_W-1:DRIVE_W-1]) || !(|acc_sh[ACC_W-1:DRIVE_W-1])) begin
      drive_sat = acc_sh[DRIVE_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  // -------------------------------------------------------- ring update
  logic                    full;
  logic signed [ERR_W-1:0] old_e;
  logic signed [SUM_W-1:0] sum_d;
  logic [PTR_W-1:0]        wpos_d;

  assign full   = (fill_q == FILL_W'(WINDOW_DEPTH));
  // Entry 0 holds the seed until the ring first overwrites it
  assign old_e  = (seed_live_q && wpos_q == '0) ? init_q : $signed(ram_rdata);
  assign sum_d  = sum_q + SUM_W'(e_q) - (full ? SUM_W'(old_e) : '0);
  assign wpos_d = (wpos_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + PTR_W'(1);

  pwi_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (e_q),
    .re_i    (ram_re),
    .raddr_i (wpos_q),
    .rdata_o (ram_rdata)
  );

  // ----------------------------------------------- control and state regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      init_q      <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      fill_q      <= FILL_W'(1);
      wpos_q      <= PTR_W'(1 % WINDOW_DEPTH);
      seed_live_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROP_GAIN:     kp_q   <= cfg_wdata_i;
          REG_INTEG_GAIN:    ki_q   <= cfg_wdata_i;
          REG_DERIV_GAIN:    kd_q   <= cfg_wdata_i;
          REG_INITIAL_ERROR: init_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (seed_wr) begin
        prev_q      <= cfg_wdata_i;
        sum_q       <= SUM_W'($signed(cfg_wdata_i));
        fill_q      <= FILL_W'(1);
        wpos_q      <= PTR_W'(1 % WINDOW_DEPTH);
        seed_live_q <= 1'b1;
      end else if (fin_go) begin
        prev_q <= e_q;
        sum_q  <= sum_d;
        wpos_q <= wpos_d;
        if (!full) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        if (wpos_q == '0) begin
          seed_live_q <= 1'b0;
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q     <= in_data_i.error_in;
      ticks_q <= in_data_i.elapsed_ticks;
    end
    case (state_q)
      ST_MUL_P: prod_q <= mul_p;
      ST_MUL_I: begin
        prod_q <= mul_p;
        acc_q  <= ACC_W'(prod_q);
      end
      ST_MUL_D: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + ACC_W'(prod_q);
      end
      ST_LOAD: begin
        n_q   <= dmag;
        rem_q <= '0;
        neg_q <= dprod[DIV_W-1];
        cnt_q <= DCNT_W'(DIV_W - 1);
      end
      ST_DIV: begin
        n_q   <= {n_q[DIV_W-2:0], qbit};
        rem_q <= qbit ? TICK_W'(rem_sh - {1'b0, ticks_q}) : rem_sh[TICK_W-1:0];
        cnt_q <= cnt_q - DCNT_W'(1);
      end
      ST_SUM: acc_q <= acc_q + dterm;
      default: ;
    endcase
    if (fin_go) begin
      out_q.drive   <= drive_sat;
      out_q.dt_zero <= (ticks_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------- assertions
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) && (fill_q <= FILL_W'(WINDOW_DEPTH)))
    else $error("fill count out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (ticks_q != '0))
    else $error("divider running with zero ticks");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second beat taken while busy");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o && in_ready_o)
    else $error("finished result not presented");

endmodule

`default_nettype wire

>>> design/pwi_ram.sv
`default_nettype none

module pwi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
